// File: rtl/ipid_pkg.sv
// Shared types and constants for the incremental PID controller with integral separation.
package ipid_pkg;

  localparam int ERR_W      = 17;
  localparam int DIFF_W     = 18;
  localparam int DDIFF_W    = 19;
  localparam int GAIN_W     = 16;
  localparam int DRIVE_W    = 32;
  localparam int PROD_W     = 36;
  localparam int SUM_W      = 38;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_PRESET = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_FLOOR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_CEILING = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_LIMIT     = 3'd6;

  typedef enum logic [1:0] {
    BASE_DRIVE = 2'd0,
    BASE_ZERO  = 2'd1,
    BASE_LOAD  = 2'd2,
    BASE_KEEP  = 2'd3
  } base_sel_t;

  typedef struct packed {
    logic [1:0]                opcode;
    logic signed [15:0]        measurement;
    logic signed [DRIVE_W-1:0] preset_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      pd_mode;
  } out_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0]         gain_p;
    logic [GAIN_W-1:0]         gain_i;
    logic [GAIN_W-1:0]         gain_d;
    logic signed [15:0]        target;
    logic signed [DRIVE_W-1:0] drive_floor;
    logic signed [DRIVE_W-1:0] drive_ceiling;
    logic [15:0]               separation_limit;
  } cfg_t;

  typedef struct packed {
    base_sel_t                 base_sel;
    logic                      pd_mode;
    logic signed [DIFF_W-1:0]  term_p;
    logic signed [ERR_W-1:0]   term_i;
    logic signed [DDIFF_W-1:0] term_d;
    logic signed [DRIVE_W-1:0] load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic busy;
  } back_stat_t;

endpackage

// File: rtl/ipid_front.sv
// Front end: accepts items, forms the error terms and keeps the error history.
module ipid_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ipid_pkg::in_item_t in_item,
  input  ipid_pkg::cfg_t   cfg,
  input  ipid_pkg::q_stat_t q_stat,
  output logic             push,
  output ipid_pkg::cmd_t   push_cmd
);
  import ipid_pkg::*;

  logic signed [ERR_W-1:0]   last_err_r, last_err_nxt;
  logic signed [ERR_W-1:0]   older_err_r, older_err_nxt;
  logic signed [ERR_W-1:0]   err;
  logic signed [DIFF_W-1:0]  diff1;
  logic signed [DDIFF_W-1:0] diff2;
  logic [ERR_W-1:0]          mag;
  logic                      sep_hit;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !in_stall;

  assign err   = ERR_W'(cfg.target) - ERR_W'(in_item.measurement);
  assign diff1 = DIFF_W'(err) - DIFF_W'(last_err_r);
  assign diff2 = DDIFF_W'(err) - (DDIFF_W'(last_err_r) <<< 1) + DDIFF_W'(older_err_r);
  assign mag   = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign sep_hit = (cfg.separation_limit != '0) && (mag >= ERR_W'(cfg.separation_limit));

  always_comb begin
    push_cmd          = '0;
    push_cmd.base_sel = BASE_KEEP;
    last_err_nxt      = last_err_r;
    older_err_nxt     = older_err_r;
    case (in_item.opcode)
      OP_UPDATE: begin
        if (sep_hit) begin
          push_cmd.base_sel = BASE_ZERO;
          push_cmd.pd_mode  = 1'b1;
          push_cmd.term_p   = DIFF_W'(err);
          push_cmd.term_d   = DDIFF_W'(diff1);
        end else begin
          push_cmd.base_sel = BASE_DRIVE;
          push_cmd.term_p   = diff1;
          push_cmd.term_i   = err;
          push_cmd.term_d   = diff2;
        end
        last_err_nxt  = err;
        older_err_nxt = last_err_r;
      end
      OP_CLEAR: begin
        push_cmd.base_sel = BASE_LOAD;
        push_cmd.load     = cfg.drive_floor;
        last_err_nxt      = '0;
        older_err_nxt     = '0;
      end
      OP_PRESET: begin
        push_cmd.base_sel = BASE_LOAD;
        push_cmd.load     = in_item.preset_value;
      end
      default: begin
        push_cmd.base_sel = BASE_KEEP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r  <= '0;
      older_err_r <= '0;
    end else if (push) begin
      last_err_r  <= last_err_nxt;
      older_err_r <= older_err_nxt;
    end
  end

endmodule

// File: rtl/ipid_queue.sv
// Short queue of classified items between the front end and the back end.
module ipid_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ipid_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output ipid_pkg::cmd_t    head,
  output ipid_pkg::q_stat_t stat
);
  import ipid_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/ipid_back.sv
// Back end: gain products, output accumulation, clamping and the output register.
module ipid_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ipid_pkg::cfg_t       cfg,
  input  ipid_pkg::q_stat_t    q_stat,
  input  ipid_pkg::cmd_t       head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ipid_pkg::out_item_t  out_item,
  output ipid_pkg::back_stat_t stat
);
  import ipid_pkg::*;

  logic                      mul_valid_r;
  logic signed [PROD_W-1:0]  prod_p_r, prod_i_r, prod_d_r;
  base_sel_t                 base_sel_r;
  logic                      pd_r;
  logic signed [DRIVE_W-1:0] load_r;
  logic signed [DRIVE_W-1:0] drive_r;
  logic                      out_valid_r;
  out_item_t                 out_item_r;

  logic                      fire;
  logic signed [PROD_W-1:0]  prod_p, prod_i, prod_d;
  logic signed [DRIVE_W-1:0] base;
  logic signed [SUM_W-1:0]   sum, ceil_x, floor_x, upper, limited;
  logic signed [DRIVE_W-1:0] result;

  assign fire      = mul_valid_r && (!out_valid_r || !out_stall);
  assign pop       = !q_stat.empty && (!mul_valid_r || fire);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign stat.busy = mul_valid_r;

  assign prod_p = PROD_W'($signed({1'b0, cfg.gain_p})) * PROD_W'(head.term_p);
  assign prod_i = PROD_W'($signed({1'b0, cfg.gain_i})) * PROD_W'(head.term_i);
  assign prod_d = PROD_W'($signed({1'b0, cfg.gain_d})) * PROD_W'(head.term_d);

  always_comb begin
    case (base_sel_r)
      BASE_DRIVE: base = drive_r;
      BASE_ZERO:  base = '0;
      BASE_LOAD:  base = load_r;
      BASE_KEEP:  base = drive_r;
      default:    base = drive_r;
    endcase
  end

  assign sum     = SUM_W'(base) + SUM_W'(prod_p_r) + SUM_W'(prod_i_r) + SUM_W'(prod_d_r);
  assign ceil_x  = SUM_W'(cfg.drive_ceiling);
  assign floor_x = SUM_W'(cfg.drive_floor);
  assign upper   = (sum > ceil_x) ? ceil_x : sum;
  assign limited = (upper < floor_x) ? floor_x : upper;
  assign result  = (base_sel_r == BASE_KEEP) ? drive_r : DRIVE_W'(limited);

  always_ff @(posedge clk) begin
    if (pop) begin
      prod_p_r   <= prod_p;
      prod_i_r   <= prod_i;
      prod_d_r   <= prod_d;
      base_sel_r <= head.base_sel;
      pd_r       <= head.pd_mode;
      load_r     <= head.load;
    end
    if (fire) begin
      out_item_r.drive   <= result;
      out_item_r.pd_mode <= pd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      drive_r     <= '0;
    end else begin
      if (pop) begin
        mul_valid_r <= 1'b1;
      end else if (fire) begin
        mul_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        drive_r     <= result;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/incremental_pid_integral_separation_core.sv
// Top level of the incremental PID controller with integral separation.
//
//   Channel | Ports                            | Direction
//   --------+----------------------------------+----------
//   input   | in_valid, in_stall, in_item      | item in
//   result  | out_valid, out_stall, out_item   | item out
//   config  | cfg_we, cfg_index, cfg_wdata     | write only
//
// One item is taken per cycle while the queue is not full; each item passes through the
// queue slot, the product registers and the output register before its result appears.
// The output feedback loop (the sum and the clamp in the back end) sets the clock.
// Reset is synchronous and active low; it loads the register defaults and clears
// the error history, the output level and the queue.
// A stall on the result side fills the queue; the input stalls only when it is full.
module incremental_pid_integral_separation_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ipid_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ipid_pkg::out_item_t               out_item,
  input  logic                              cfg_we,
  input  logic [ipid_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ipid_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ipid_pkg::*;

  cfg_t       cfg_r;
  q_stat_t    q_stat;
  back_stat_t back_stat;
  cmd_t       push_cmd, head;
  logic       push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p           <= 16'd256;
      cfg_r.gain_i           <= '0;
      cfg_r.gain_d           <= '0;
      cfg_r.target           <= '0;
      cfg_r.drive_floor      <= '0;
      cfg_r.drive_ceiling    <= 32'sd6553600;
      cfg_r.separation_limit <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_P:        cfg_r.gain_p           <= cfg_wdata[15:0];
        REG_GAIN_I:        cfg_r.gain_i           <= cfg_wdata[15:0];
        REG_GAIN_D:        cfg_r.gain_d           <= cfg_wdata[15:0];
        REG_TARGET:        cfg_r.target           <= cfg_wdata[15:0];
        REG_DRIVE_FLOOR:   cfg_r.drive_floor      <= cfg_wdata;
        REG_DRIVE_CEILING: cfg_r.drive_ceiling    <= cfg_wdata;
        REG_SEP_LIMIT:     cfg_r.separation_limit <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  ipid_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .cfg      (cfg_r),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  ipid_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  ipid_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .stat      (back_stat)
  );

`ifndef SYNTH
  // The queue can never report full and empty together.
  assert property (@(posedge clk) disable iff (!rst_n) !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

  // An item pushed into an empty queue is still there in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && q_stat.empty) |=> !q_stat.empty)
    else $error("item lost on entry to the queue");

  // The back end keeps its item while the output register is held.
  assert property (@(posedge clk) disable iff (!rst_n)
    (back_stat.busy && out_valid && out_stall) |=> back_stat.busy)
    else $error("back end dropped an item during a stall");
`endif

endmodule
